/* rtl/gwc_pkg.sv */
// Package for the glyph width lookup cache.
// Holds sizes, the node type and the UTF-8 decode function; no dependencies.
package gwc_pkg;
  localparam int CACHE_ENTRIES = 512;
  localparam int DROP_ENTRIES  = CACHE_ENTRIES / 4;
  localparam int KEEP_ENTRIES  = CACHE_ENTRIES - DROP_ENTRIES;
  localparam int TREE_LEVELS   = $clog2(CACHE_ENTRIES);
  localparam int TREE_LEAVES   = 1 << TREE_LEVELS;
  localparam int COUNT_W       = $clog2(CACHE_ENTRIES + 1);
  localparam int KEY_W         = 21;
  localparam int WIDTH_W       = 12;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX = '1;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_FILL   = 1'b1;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [WIDTH_W-1:0] wid_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic found;
    wid_t width;
  } node_t;

  function automatic key_t decode_cp(input logic [31:0] bytes);
    logic [7:0] b0;
    logic [5:0] b1;
    logic [5:0] b2;
    logic [5:0] b3;
    key_t       cp;
    b0 = bytes[7:0];
    b1 = bytes[13:8];
    b2 = bytes[21:16];
    b3 = bytes[29:24];
    if (b0[7] == 1'b0) begin
      cp = {13'd0, b0};
    end else if ((b0 & 8'hE0) == 8'hC0) begin
      cp = {10'd0, b0[4:0], b1};
    end else if ((b0 & 8'hF0) == 8'hE0) begin
      cp = {5'd0, b0[3:0], b1, b2};
    end else if ((b0 & 8'hF8) == 8'hF0) begin
      cp = {b0[2:0], b1, b2, b3};
    end else begin
      cp = {13'd0, b0};
    end
    return cp;
  endfunction
endpackage

/* rtl/gwc_cell.sv */
// One store cell: holds one code point and width pair, hands it to the next
// cell on a fill shift, and registers its own match result. Uses gwc_pkg.
module gwc_cell (
  input  logic          clk,
  input  logic          shift,
  input  gwc_pkg::key_t key_in,
  input  gwc_pkg::wid_t wid_in,
  input  logic          cmp,
  input  logic          live,
  input  gwc_pkg::key_t cmp_key,
  output gwc_pkg::key_t key_out,
  output gwc_pkg::wid_t wid_out,
  output gwc_pkg::node_t leaf
);
  import gwc_pkg::*;

  key_t key;
  wid_t wid;

  always_ff @(posedge clk) begin
    if (shift) begin
      key <= key_in;
      wid <= wid_in;
    end
    if (cmp) begin
      leaf.found <= live && (key == cmp_key);
      leaf.width <= wid;
    end
  end

  assign key_out = key;
  assign wid_out = wid;
endmodule

/* rtl/gwc_tree.sv */
// Registered binary pick tree over the cell match results; the older entry
// (higher cell index) wins. Every tree level is registered. Uses gwc_pkg.
module gwc_tree (
  input  logic           clk,
  input  gwc_pkg::node_t leaves [gwc_pkg::CACHE_ENTRIES],
  output gwc_pkg::node_t root
);
  import gwc_pkg::*;

  node_t base  [TREE_LEAVES];
  node_t nodes [1:TREE_LEAVES-1];

  genvar g;
  generate
    for (g = 0; g < TREE_LEAVES; g++) begin : g_leaf
      if (g < CACHE_ENTRIES) begin : g_real
        assign base[g] = leaves[g];
      end else begin : g_pad
        assign base[g] = '0;
      end
    end
    for (g = 1; g < TREE_LEAVES; g++) begin : g_node
      if (2*g >= TREE_LEAVES) begin : g_low
        always_ff @(posedge clk) begin
          nodes[g] <= base[2*g+1-TREE_LEAVES].found ? base[2*g+1-TREE_LEAVES]
                                                    : base[2*g-TREE_LEAVES];
        end
      end else begin : g_up
        always_ff @(posedge clk) begin
          nodes[g] <= nodes[2*g+1].found ? nodes[2*g+1] : nodes[2*g];
        end
      end
    end
  endgenerate

  assign root = nodes[1];
endmodule

/* rtl/glyph_width_lookup_cache.sv */
// Glyph width lookup cache: top level with request register, cell row,
// pick tree and result register. Uses gwc_pkg, gwc_cell, gwc_tree.
// done rises after the request register, the cell match registers, the registered
// pick tree and the result register; one item at a time. busy stays high until
// the result cycle; next accept at the edge ending it; the receiver cannot stall.
// Reset clears the entry count, the font, the pipeline tokens and done.
module glyph_width_lookup_cache (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [15:0] font_handle,
  input  logic [31:0] char_bytes,
  input  logic [3:0]  byte_len,
  input  logic [15:0] fill_width,
  output logic        done,
  output logic        hit,
  output logic [11:0] width,
  output logic        invalid
);
  import gwc_pkg::*;

  logic        req_v;
  logic        req_op;
  logic        req_bad;
  logic [15:0] req_font;
  key_t        req_key;
  wid_t        req_wid;
  logic [TREE_LEVELS:0] pipe;
  count_t      count;
  count_t      count_next;
  count_t      eff_count;
  logic [15:0] cur_font;
  logic        accept;
  logic        do_fill;

  key_t  kchain [CACHE_ENTRIES+1];
  wid_t  wchain [CACHE_ENTRIES+1];
  node_t leaves [CACHE_ENTRIES];
  node_t root;

  assign accept  = start && !busy;
  assign busy    = req_v || (|pipe);
  assign do_fill = req_v && !req_bad && (req_op == OP_FILL);

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op   <= operation;
      req_bad  <= (font_handle == 16'd0) || (byte_len == 4'd0) || (byte_len > 4'd4);
      req_font <= font_handle;
      req_key  <= decode_cp(char_bytes);
      req_wid  <= (fill_width > 16'(WIDTH_MAX)) ? WIDTH_MAX : fill_width[WIDTH_W-1:0];
    end
  end

  always_comb begin
    eff_count = (req_font != cur_font) ? '0 : count;
    if (do_fill) begin
      if (eff_count >= count_t'(CACHE_ENTRIES)) begin
        count_next = count_t'(KEEP_ENTRIES + 1);
      end else begin
        count_next = eff_count + count_t'(1);
      end
    end else begin
      count_next = eff_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_v    <= 1'b0;
      pipe     <= '0;
      count    <= '0;
      cur_font <= '0;
      done     <= 1'b0;
    end else begin
      req_v <= accept;
      pipe  <= {pipe[TREE_LEVELS-1:0], req_v};
      done  <= pipe[TREE_LEVELS];
      if (req_v && !req_bad) begin
        count    <= count_next;
        cur_font <= req_font;
      end
    end
  end

  assign kchain[0] = req_key;
  assign wchain[0] = req_wid;

  genvar g;
  generate
    for (g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
      gwc_cell u_cell (
        .clk    (clk),
        .shift  (do_fill),
        .key_in (kchain[g]),
        .wid_in (wchain[g]),
        .cmp    (req_v),
        .live   (eff_count > count_t'(g)),
        .cmp_key(req_key),
        .key_out(kchain[g+1]),
        .wid_out(wchain[g+1]),
        .leaf   (leaves[g])
      );
    end
  endgenerate

  gwc_tree u_tree (
    .clk   (clk),
    .leaves(leaves),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (pipe[TREE_LEVELS]) begin
      invalid <= req_bad;
      hit     <= !req_bad && (req_op == OP_LOOKUP) && root.found;
      width   <= (!req_bad && (req_op == OP_LOOKUP) && root.found) ? root.width : '0;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0({req_v, pipe}))
    else $error("more than one item in flight");
  a_hit_valid: assert property (@(posedge clk) disable iff (rst) done && hit |-> !invalid)
    else $error("hit on invalid item");
  a_width_hit: assert property (@(posedge clk) disable iff (rst)
    done && (width != 12'd0) |-> hit)
    else $error("width without hit");
`endif
endmodule

/* tb/testbench.sv */
// Testbench for glyph_width_lookup_cache: drives lookup and fill items from a
// queue, predicts hit, width and invalid with its own store model and checks
// each done strobe. Depends on gwc_pkg and the RTL only.
`timescale 1ns / 100ps

module testbench;
  import gwc_pkg::*;

  typedef struct {
    logic        op;
    logic [15:0] font;
    logic [31:0] bytes;
    logic [3:0]  len;
    logic [15:0] fw;
    logic        pause;
  } item_t;

  typedef struct {
    logic        hit;
    logic [11:0] width;
    logic        invalid;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        operation = 1'b0;
  logic [15:0] font_handle = '0;
  logic [31:0] char_bytes = '0;
  logic [3:0]  byte_len = '0;
  logic [15:0] fill_width = '0;
  logic        done;
  logic        hit;
  logic [11:0] width;
  logic        invalid;

  item_t  pending_items[$];
  reply_t expected_replies[$];
  key_t   model_keys[$];
  wid_t   model_widths[$];
  logic [15:0] model_font = '0;
  int     errors = 0;
  int     cycles = 0;
  int     sent = 0;
  int     hits_seen = 0;
  int     fills_seen = 0;
  int     invalids_seen = 0;
  int     idle_pct = 29;

  glyph_width_lookup_cache uut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic key_t cp_of(logic [31:0] b);
    logic [7:0] b0;
    b0 = b[7:0];
    if (!b0[7]) return key_t'(b0);
    if (b0[7:5] == 3'b110) return key_t'({b0[4:0], b[13:8]});
    if (b0[7:4] == 4'b1110) return key_t'({b0[3:0], b[13:8], b[21:16]});
    if (b0[7:3] == 5'b11110) return key_t'({b0[2:0], b[13:8], b[21:16], b[29:24]});
    return key_t'(b0);
  endfunction

  function automatic reply_t predict_width(item_t it);
    reply_t r;
    key_t   k;
    r = '{1'b0, 12'd0, 1'b0};
    if (it.font == 0 || it.len < 1 || it.len > 4) begin
      r.invalid = 1'b1;
      return r;
    end
    if (it.font != model_font) begin
      model_keys.delete();
      model_widths.delete();
      model_font = it.font;
    end
    k = cp_of(it.bytes);
    if (it.op == OP_LOOKUP) begin
      foreach (model_keys[i]) begin
        if (model_keys[i] == k) begin
          r.hit = 1'b1;
          r.width = model_widths[i];
          break;
        end
      end
    end else begin
      if (model_keys.size() >= CACHE_ENTRIES) begin
        repeat (DROP_ENTRIES) begin
          void'(model_keys.pop_front());
          void'(model_widths.pop_front());
        end
      end
      model_keys.push_back(k);
      model_widths.push_back(it.fw > 16'd4095 ? 12'd4095 : it.fw[11:0]);
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_char(int kind);
    logic [31:0] b;
    b = $urandom;
    case (kind)
      0: b[7:0] = 8'($urandom_range(0, 127));
      1: b[7:5] = 3'b110;
      2: b[7:4] = 4'b1110;
      3: b[7:3] = 5'b11110;
      default: b[7:0] = 8'($urandom_range(128, 255));
    endcase
    return b;
  endfunction

  task automatic add(logic op, logic [15:0] f, logic [31:0] b, logic [3:0] l,
                     logic [15:0] w, logic p = 1'b0);
    pending_items.push_back('{op, f, b, l, w, p});
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !busy) && start) begin
      start <= 1'b1;
    end else if (pending_items.size() == 0 ||
                 (pending_items[0].pause && expected_replies.size() != 0) ||
                 $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
    end else begin
      item_t it;
      it = pending_items.pop_front();
      expected_replies.push_back(predict_width(it));
      if (it.op == OP_FILL && !expected_replies[$].invalid) fills_seen++;
      operation   <= it.op;
      font_handle <= it.font;
      char_bytes  <= it.bytes;
      byte_len    <= it.len;
      fill_width  <= it.fw;
      start       <= 1'b1;
      sent++;
      if (sent == 220) idle_pct = 49;
      if (sent == 440) idle_pct = 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result hit=%0b width=%0d invalid=%0b",
                 $time, hit, width, invalid);
        errors++;
      end else begin
        reply_t e;
        e = expected_replies.pop_front();
        if (e.hit) hits_seen++;
        if (e.invalid) invalids_seen++;
        if (hit !== e.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
          errors++;
        end
        if (width !== e.width) begin
          $display("%0t: width expected %0d actual %0d", $time, e.width, width);
          errors++;
        end
        if (invalid !== e.invalid) begin
          $display("%0t: invalid expected %0b actual %0b", $time, e.invalid, invalid);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int f;
    int n;
    logic [31:0] b;
    // directed: extremes, invalid cases, malformed leads, saturation
    add(OP_LOOKUP, 16'h0001, 32'h0000_0041, 4'd1, 16'd0);
    add(OP_FILL,   16'h0001, 32'h0000_0041, 4'd1, 16'hFFFF);
    add(OP_LOOKUP, 16'h0001, 32'h0000_0041, 4'd1, 16'd0);
    add(OP_FILL,   16'h0001, 32'hFFFF_FFC3, 4'd2, 16'd4095);
    add(OP_LOOKUP, 16'h0001, 32'h3F3F_3FC3, 4'd3, 16'd0);
    add(OP_FILL,   16'h0001, 32'h0080_80EF, 4'd3, 16'd4096);
    add(OP_LOOKUP, 16'h0001, 32'hC0C0_80EF, 4'd3, 16'd0);
    add(OP_FILL,   16'h0001, 32'hBFBF_BFF7, 4'd4, 16'd7);
    add(OP_LOOKUP, 16'h0001, 32'h3F3F_3FF7, 4'd4, 16'd0);
    add(OP_FILL,   16'h0001, 32'h1234_56FF, 4'd2, 16'd9);
    add(OP_LOOKUP, 16'h0001, 32'h0000_00FF, 4'd1, 16'd0);
    add(OP_LOOKUP, 16'h0001, 32'h0000_0080, 4'd1, 16'd0);
    add(OP_FILL,   16'h0001, 32'h0000_0041, 4'd1, 16'd5);
    add(OP_LOOKUP, 16'h0001, 32'h0000_0041, 4'd1, 16'd0);
    add(OP_FILL,   16'h0000, 32'h0000_0042, 4'd1, 16'd3);
    add(OP_FILL,   16'h0001, 32'h0000_0042, 4'd0, 16'd3);
    add(OP_LOOKUP, 16'h0001, 32'h0000_0042, 4'd15, 16'd0);
    add(OP_LOOKUP, 16'h0001, 32'h0000_0042, 4'd5, 16'd0);
    add(OP_LOOKUP, 16'hFFFF, 32'h0000_0041, 4'd1, 16'd0, 1'b1);
    add(OP_LOOKUP, 16'h0001, 32'h0000_0041, 4'd1, 16'd0);
    // fill past capacity to exercise the quarter drop
    for (int i = 0; i < CACHE_ENTRIES + 40; i++)
      add(OP_FILL, 16'h0002, {11'd0, 21'(i)}, 4'd1, 16'($urandom));
    for (int i = 0; i < 20; i++)
      add(OP_LOOKUP, 16'h0002, {11'd0, 21'($urandom_range(0, CACHE_ENTRIES + 40))},
          4'd1, 16'd0);
    // random: mixed fills and lookups with rare font changes and some invalid items
    f = 3;
    n = 0;
    while (n < 60) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) f = $urandom_range(1, 65535);
      b = rand_char($urandom_range(0, 4));
      if ($urandom_range(0, 1)) b[7:0] = 8'($urandom_range(0, 15)) | (b[7:0] & 8'hF0);
      if (r < 6)
        add(1'($urandom), $urandom_range(0, 3) == 0 ? 16'd0 : 16'(f), $urandom,
            4'($urandom), 16'($urandom), n == 30);
      else
        add(r < 45 ? OP_FILL : OP_LOOKUP, 16'(f), b, 4'($urandom_range(1, 4)),
            16'($urandom), n == 30);
      n++;
    end
    while (pending_items.size() != 0 || start) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("sent %0d items: %0d fills, %0d hits, %0d invalid", sent, fills_seen,
             hits_seen, invalids_seen);
    $display("covered font flushes, store overflow, malformed leads, saturation");
    if (errors == 0 && expected_replies.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end
endmodule

/* filelist.f */
rtl/gwc_pkg.sv
rtl/gwc_cell.sv
rtl/gwc_tree.sv
rtl/glyph_width_lookup_cache.sv
tb/testbench.sv
